/* design/vap_pkg.sv */
// ----------------------------------------------------------------------------
// vap_pkg
// Shared codes and types for the voice allocator with priority stealing.
// ----------------------------------------------------------------------------
package vap_pkg;

  // event codes
  localparam logic [2:0] ACT_NOTE_ON   = 3'd0;
  localparam logic [2:0] ACT_NOTE_OFF  = 3'd1;
  localparam logic [2:0] ACT_PEDAL_REL = 3'd2;
  localparam logic [2:0] ACT_TRACK_OFF = 3'd3;
  localparam logic [2:0] ACT_KILL_ALL  = 3'd4;
  localparam logic [2:0] ACT_FINISHED  = 3'd5;

  // choice kinds
  localparam logic [2:0] KIND_SAME  = 3'd0;
  localparam logic [2:0] KIND_FREE  = 3'd1;
  localparam logic [2:0] KIND_REL   = 3'd2;
  localparam logic [2:0] KIND_STEAL = 3'd3;
  localparam logic [2:0] KIND_NONE  = 3'd4;

  // voice status
  localparam logic [1:0] ST_OFF = 2'd0;
  localparam logic [1:0] ST_ON  = 2'd1;
  localparam logic [1:0] ST_REL = 2'd2;

  localparam logic [7:0] PRIO_BASE    = 8'h40;
  localparam logic [4:0] CFG_RESET    = 5'd12;
  localparam logic [5:0] RELEASED_MAX = 6'd31;

  typedef struct packed {
    logic capture;  // latch the incoming item
    logic match;    // register per-voice match vectors
    logic pick;     // priority-select and build update masks
    logic commit;   // apply updates and load the result register
  } cmd_t;

endpackage

/* design/vap_ctrl.sv */
// ----------------------------------------------------------------------------
// vap_ctrl
// Sequencer for the voice allocator: capture, match, pick, commit.
// ----------------------------------------------------------------------------
module vap_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output vap_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MATCH  = 4'b0010,
    S_PICK   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   commit_ok;

  // the result register must be empty or emptying before a commit
  assign commit_ok = (state == S_COMMIT) && (!out_valid || out_ready);
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_MATCH;
      end
      S_MATCH:  state_next = S_PICK;
      S_PICK:   state_next = S_COMMIT;
      S_COMMIT: begin
        if (commit_ok) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (commit_ok) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_comb begin
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.match   = (state == S_MATCH);
    cmd.pick    = (state == S_PICK);
    cmd.commit  = commit_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* design/vap_datapath.sv */
// ----------------------------------------------------------------------------
// vap_datapath
// Voice table, per-voice match lanes, priority select and result register.
// ----------------------------------------------------------------------------
module vap_datapath #(
  parameter int VOICE_COUNT = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  vap_pkg::cmd_t cmd,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_wdata,
  input  logic [2:0]    action,
  input  logic [5:0]    owner_tag,
  input  logic [5:0]    track_rank,
  input  logic [6:0]    track_priority,
  input  logic [6:0]    note_number,
  input  logic          sustain_held,
  input  logic [3:0]    voice_slot,
  output logic          granted,
  output logic [3:0]    voice_chosen,
  output logic [2:0]    choice_kind,
  output logic [4:0]    voices_released
);

  localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [5:0] VOICE_LIMIT = 6'(VOICE_COUNT);

  // configuration
  logic [4:0] voices_in_use;
  logic [5:0] scan_len;

  // captured item
  logic [2:0]  act;
  logic [5:0]  tag;
  logic [14:0] prio;
  logic [6:0]  note;
  logic        sus;
  logic [3:0]  slot;

  // voice table
  logic [1:0]  v_status [VOICE_COUNT];
  logic [5:0]  v_owner  [VOICE_COUNT];
  logic        v_ovalid [VOICE_COUNT];
  logic [6:0]  v_note   [VOICE_COUNT];
  logic [14:0] v_prio   [VOICE_COUNT];
  logic        v_smark  [VOICE_COUNT];

  // match vectors
  logic [VOICE_COUNT-1:0] hit_c, off_c, rel_c, steal_c, grp_c, fin_c;
  logic [VOICE_COUNT-1:0] hit_v, off_v, rel_v, steal_v, grp_v, fin_v;

  // pick stage
  logic [VOICE_COUNT-1:0] sel_src, sel_1h, hit_1h, on_mask;
  logic [VOICE_COUNT-1:0] alloc_c, relm_c, mset_c, mclr_c;
  logic [VOICE_COUNT-1:0] alloc_m, relm_m, mset_m, mclr_m, finm_m;
  logic [VIDX_W-1:0]      idx_c, chosen;
  logic [2:0]             kind_c, kind;
  logic                   grant_c, grant;
  logic [5:0]             cnt_raw;
  logic [4:0]             cnt_c, cnt;
  logic [VIDX_W+3:0]      chosen_ext;

  assign scan_len = ({1'b0, voices_in_use} > VOICE_LIMIT) ? VOICE_LIMIT
                                                           : {1'b0, voices_in_use};

  always_ff @(posedge clk) begin
    if (rst) begin
      voices_in_use <= vap_pkg::CFG_RESET;
    end else if (cfg_we) begin
      voices_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act  <= action;
      tag  <= owner_tag;
      prio <= {track_priority, 8'(vap_pkg::PRIO_BASE - {2'b00, track_rank})};
      note <= note_number;
      sus  <= sustain_held;
      slot <= voice_slot;
    end
  end

  // per-voice lanes
  always_comb begin
    for (int i = 0; i < VOICE_COUNT; i++) begin
      logic active, owned, nonoff;
      active     = (6'(i) < scan_len);
      owned      = v_ovalid[i] && (v_owner[i] == tag);
      nonoff     = (v_status[i] != vap_pkg::ST_OFF);
      hit_c[i]   = active && owned && (v_note[i] == note);
      off_c[i]   = active && (v_status[i] == vap_pkg::ST_OFF);
      rel_c[i]   = active && (v_status[i] == vap_pkg::ST_REL);
      steal_c[i] = active && (prio >= v_prio[i]);
      fin_c[i]   = (act == vap_pkg::ACT_FINISHED) && (6'(i) == {2'b00, slot});
      on_mask[i] = (v_status[i] == vap_pkg::ST_ON);
      case (act)
        vap_pkg::ACT_PEDAL_REL: grp_c[i] = active && owned && v_smark[i];
        vap_pkg::ACT_TRACK_OFF: grp_c[i] = active && owned && nonoff;
        vap_pkg::ACT_KILL_ALL:  grp_c[i] = active && nonoff;
        default:                grp_c[i] = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit_v   <= hit_c;
      off_v   <= off_c;
      rel_v   <= rel_c;
      steal_v <= steal_c;
      grp_v   <= grp_c;
      fin_v   <= fin_c;
    end
  end

  // priority select over the registered vectors
  always_comb begin
    grant_c = 1'b1;
    if (|hit_v) begin
      sel_src = hit_v;
      kind_c  = vap_pkg::KIND_SAME;
    end else if (|off_v) begin
      sel_src = off_v;
      kind_c  = vap_pkg::KIND_FREE;
    end else if (|rel_v) begin
      sel_src = rel_v;
      kind_c  = vap_pkg::KIND_REL;
    end else if (|steal_v) begin
      sel_src = steal_v;
      kind_c  = vap_pkg::KIND_STEAL;
    end else begin
      sel_src = '0;
      kind_c  = vap_pkg::KIND_NONE;
      grant_c = 1'b0;
    end
    // lowest set bit
    sel_1h = sel_src & (~sel_src + 1'b1);
    hit_1h = hit_v & (~hit_v + 1'b1);
    idx_c  = '0;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      if (sel_1h[i]) idx_c = idx_c | VIDX_W'(i);
    end
    alloc_c = '0;
    relm_c  = '0;
    mset_c  = '0;
    mclr_c  = '0;
    case (act)
      vap_pkg::ACT_NOTE_ON: begin
        alloc_c = sel_1h;
      end
      vap_pkg::ACT_NOTE_OFF: begin
        if (sus) mset_c = hit_1h;
        else relm_c = hit_1h;
      end
      vap_pkg::ACT_PEDAL_REL: begin
        relm_c = grp_v;
        mclr_c = grp_v;
      end
      vap_pkg::ACT_TRACK_OFF, vap_pkg::ACT_KILL_ALL: begin
        relm_c = grp_v;
      end
      default: ;
    endcase
    if (act != vap_pkg::ACT_NOTE_ON) begin
      grant_c = 1'b0;
      kind_c  = vap_pkg::KIND_NONE;
      idx_c   = '0;
    end
    cnt_raw = 6'($countones(relm_c & on_mask));
    cnt_c   = (cnt_raw > vap_pkg::RELEASED_MAX) ? 5'(vap_pkg::RELEASED_MAX) : cnt_raw[4:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      alloc_m <= alloc_c;
      relm_m  <= relm_c;
      mset_m  <= mset_c;
      mclr_m  <= mclr_c;
      finm_m  <= fin_v;
      grant   <= grant_c;
      kind    <= kind_c;
      chosen  <= idx_c;
      cnt     <= cnt_c;
    end
  end

  // voice table update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        v_status[i] <= vap_pkg::ST_OFF;
        v_owner[i]  <= '0;
        v_ovalid[i] <= 1'b0;
        v_note[i]   <= '0;
        v_prio[i]   <= '0;
        v_smark[i]  <= 1'b0;
      end
    end else if (cmd.commit) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        if (alloc_m[i]) begin
          v_status[i] <= vap_pkg::ST_ON;
          v_owner[i]  <= tag;
          v_ovalid[i] <= 1'b1;
          v_note[i]   <= note;
          v_prio[i]   <= prio;
          v_smark[i]  <= 1'b0;
        end
        if (relm_m[i]) begin
          v_status[i] <= vap_pkg::ST_REL;
          v_ovalid[i] <= 1'b0;
        end
        if (mclr_m[i]) v_smark[i] <= 1'b0;
        if (mset_m[i]) v_smark[i] <= 1'b1;
        if (finm_m[i]) begin
          v_status[i] <= vap_pkg::ST_OFF;
          v_ovalid[i] <= 1'b0;
          v_smark[i]  <= 1'b0;
        end
      end
    end
  end

  assign chosen_ext = {4'b0000, chosen};

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      granted         <= grant;
      voice_chosen    <= chosen_ext[3:0];
      choice_kind     <= kind;
      voices_released <= cnt;
    end
  end

endmodule

/* design/voice_allocator_priority_steal_core.sv */
// an accepted item passes through the match, pick and commit states before its result
//   is valid; a new item is taken only once the block is back in the idle state after
//   the commit of the last one; commit waits while the result is held
// reset (rst, synchronous): all voices off and unowned, voices_in_use = 12,
//   no result pending; the block is ready in the cycle after reset
// ----------------------------------------------------------------------------
// voice_allocator_priority_steal_core
// Synthesizer voice pool with note-on allocation and priority stealing.
// ----------------------------------------------------------------------------
module voice_allocator_priority_steal_core #(
  parameter int VOICE_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] action,
  input  logic [5:0] owner_tag,
  input  logic [5:0] track_rank,
  input  logic [6:0] track_priority,
  input  logic [6:0] note_number,
  input  logic       sustain_held,
  input  logic [3:0] voice_slot,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       granted,
  output logic [3:0] voice_chosen,
  output logic [2:0] choice_kind,
  output logic [4:0] voices_released
);

  vap_pkg::cmd_t cmd;

  vap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  vap_datapath #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .action          (action),
    .owner_tag       (owner_tag),
    .track_rank      (track_rank),
    .track_priority  (track_priority),
    .note_number     (note_number),
    .sustain_held    (sustain_held),
    .voice_slot      (voice_slot),
    .granted         (granted),
    .voice_chosen    (voice_chosen),
    .choice_kind     (choice_kind),
    .voices_released (voices_released)
  );

endmodule

/* design/vap_checker.sv */
// ----------------------------------------------------------------------------
// vap_checker
// Port-level checks for the voice allocator core, attached by bind.
// ----------------------------------------------------------------------------
module vap_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       granted,
  input logic [3:0] voice_chosen,
  input logic [2:0] choice_kind,
  input logic [4:0] voices_released
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(granted) &&
      $stable(voice_chosen) && $stable(choice_kind) && $stable(voices_released))
    else $error("result changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // no grant means default kind and index
  a_no_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> voice_chosen == 4'd0 && choice_kind == vap_pkg::KIND_NONE)
    else $error("ungranted result carries a choice");

  // a grant is only for note on, which releases nothing
  a_grant_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted |-> choice_kind < vap_pkg::KIND_NONE &&
      voices_released == 5'd0)
    else $error("granted result with bad kind or release count");

endmodule

bind voice_allocator_priority_steal_core vap_checker u_vap_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .granted         (granted),
  .voice_chosen    (voice_chosen),
  .choice_kind     (choice_kind),
  .voices_released (voices_released)
);
